/* src/ohs_pkg.sv */
// shared types, codes and hash function of the open-addressing hash set
package ohs_pkg;

  // operation codes of a request
  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_TEST   = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  // slot status codes
  localparam logic [1:0] ST_EMPTY = 2'd0;
  localparam logic [1:0] ST_LIVE  = 2'd1;
  localparam logic [1:0] ST_TOMB  = 2'd2;

  localparam int KEY_W  = 64;
  localparam int HASH_W = 16;
  localparam int LIVE_W = 10;

  // classified request held in the queue
  typedef struct packed {
    logic [1:0]        op;
    logic [KEY_W-1:0]  key;
    logic [HASH_W-1:0] hash;
  } req_t;

  // h = 3h + byte over all bytes equals the sum of byte i times 3^i, kept modulo 2^16;
  // summed as a tree of pairs; any power-of-two size masks it
  function automatic logic [HASH_W-1:0] hash16(input logic [KEY_W-1:0] k);
    logic [HASH_W-1:0] b [8];
    logic [HASH_W-1:0] s [4];
    logic [HASH_W-1:0] q [2];
    for (int i = 0; i < 8; i++) begin
      b[i] = HASH_W'(k[8*i +: 8]);
    end
    for (int j = 0; j < 4; j++) begin
      s[j] = b[2*j] + HASH_W'(3) * b[2*j+1];
    end
    for (int j = 0; j < 2; j++) begin
      q[j] = s[2*j] + HASH_W'(9) * s[2*j+1];
    end
    return q[0] + HASH_W'(81) * q[1];
  endfunction

  // log2 of the largest power of two not above either bound
  function automatic int start_log(input int s, input int m);
    int lg;
    lg = 0;
    while (lg < 16 && (2 << lg) <= s && (2 << lg) <= m) begin
      lg++;
    end
    return lg;
  endfunction

endpackage

/* src/ohs_if.sv */
// request and response channel interfaces
interface ohs_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [63:0] key;
  modport source (output valid, output op, output key, input ready);
  modport sink (input valid, input op, input key, output ready);
endinterface

interface ohs_rsp_if;
  logic       valid;
  logic       ready;
  logic       success;
  logic       full_res;
  logic [9:0] live_keys;
  modport source (output valid, output success, output full_res, output live_keys,
                  input ready);
  modport sink (input valid, input success, input full_res, input live_keys,
                output ready);
endinterface

/* src/open_addressing_hash_set_core.sv */
// top level: hash set with triangular probing over two slot banks
// an insert probes to search, then again to place; one request is in the prober at a time
// a growing insert first clears the new bank, then scans the old bank and rehashes
// each live key into the new bank, then clears the old bank
// reset: a clearing pass over every slot of both banks, no transaction taken
module open_addressing_hash_set_core #(
  parameter int KEY_BYTES   = 8,
  parameter int START_SLOTS = 8,
  parameter int MAX_SLOTS   = 1024
) (
  input  logic             clk,
  input  logic             rst_n,
  ohs_req_if.sink          in_ch,
  ohs_rsp_if.source        out_ch
);

  logic          clearing;
  logic          push_valid, push_ready, pop_valid, pop_ready;
  ohs_pkg::req_t push_data, pop_data;

  // classify and hash
  ohs_front #(.KEY_BYTES(KEY_BYTES)) u_front (
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .in_op      (in_ch.op),
    .in_key     (in_ch.key),
    .clearing   (clearing),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  // decoupling queue
  ohs_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  // table engine
  ohs_back #(.START_SLOTS(START_SLOTS), .MAX_SLOTS(MAX_SLOTS)) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .pop_valid     (pop_valid),
    .pop_ready     (pop_ready),
    .pop_data      (pop_data),
    .clearing      (clearing),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .out_success   (out_ch.success),
    .out_full_res  (out_ch.full_res),
    .out_live_keys (out_ch.live_keys)
  );

endmodule

/* src/ohs_front.sv */
// front end: masks the key, hashes it and hands the request to the queue
module ohs_front #(
  parameter int KEY_BYTES = 8
) (
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_op,
  input  logic [63:0]        in_key,
  input  logic               clearing,
  output logic               push_valid,
  input  logic               push_ready,
  output ohs_pkg::req_t      push_data
);

  localparam logic [63:0] KEY_MASK = (KEY_BYTES >= 8) ? {64{1'b1}} :
                                     ((64'd1 << (8 * KEY_BYTES)) - 64'd1);

  logic [63:0] key_m;

  // no transaction taken while the table is being cleared
  assign in_ready   = push_ready & ~clearing;
  assign push_valid = in_valid & ~clearing;

  // classify the request
  always_comb begin
    key_m          = in_key & KEY_MASK;
    push_data.op   = in_op;
    push_data.key  = key_m;
    push_data.hash = ohs_pkg::hash16(key_m);
  end

endmodule

/* src/ohs_queue.sv */
// two-entry request queue between front and back
module ohs_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push_valid,
  output logic          push_ready,
  input  ohs_pkg::req_t push_data,
  output logic          pop_valid,
  input  logic          pop_ready,
  output ohs_pkg::req_t pop_data
);

  ohs_pkg::req_t mem_r [2];
  logic       wp_r, wp_nxt;
  logic       rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push, pop;

  assign push_ready = (cnt_r != 2'd2);
  assign pop_valid  = (cnt_r != 2'd0);
  assign pop_data   = mem_r[rp_r];
  assign push       = push_valid & push_ready;
  assign pop        = pop_valid & pop_ready;

  // pointer and count update
  always_comb begin
    wp_nxt  = wp_r ^ push;
    rp_nxt  = rp_r ^ pop;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_data;
    end
  end

endmodule

/* src/ohs_back.sv */
// back end: probe walks, growth rehash and slot memories
module ohs_back #(
  parameter int START_SLOTS = 8,
  parameter int MAX_SLOTS   = 1024
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          pop_valid,
  output logic          pop_ready,
  input  ohs_pkg::req_t pop_data,
  output logic          clearing,
  output logic          out_valid,
  input  logic          out_ready,
  output logic          out_success,
  output logic          out_full_res,
  output logic [9:0]    out_live_keys
);

  localparam int SW  = $clog2(MAX_SLOTS);
  localparam int AW  = SW + 1;
  localparam int LW  = $clog2(SW + 1);
  localparam int CW  = $clog2(MAX_SLOTS + 1);
  localparam int GW  = SW + 4;
  localparam int START_LOG = ohs_pkg::start_log(START_SLOTS, MAX_SLOTS);

  typedef enum logic [13:0] {
    S_CLR      = 14'b00000000000001,
    S_IDLE     = 14'b00000000000010,
    S_FIND_RD  = 14'b00000000000100,
    S_FIND_EV  = 14'b00000000001000,
    S_GCLR_NEW = 14'b00000000010000,
    S_GRD      = 14'b00000000100000,
    S_GEV      = 14'b00000001000000,
    S_GHASH    = 14'b00000010000000,
    S_GPRD     = 14'b00000100000000,
    S_GPEV     = 14'b00001000000000,
    S_GCLR_OLD = 14'b00010000000000,
    S_INS_RD   = 14'b00100000000000,
    S_INS_EV   = 14'b01000000000000,
    S_SPARE    = 14'b10000000000000
  } state_t;

  state_t          state_r, state_nxt;
  logic            bank_r, bank_nxt;
  logic [LW-1:0]   lg_r, lg_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic [AW-1:0]   i_r, i_nxt;
  logic            ov_r, ov_nxt;
  logic            succ_r, succ_nxt;
  logic            full_r, full_nxt;
  logic [1:0]      op_r, op_nxt;
  logic [63:0]     key_r, key_nxt;
  logic [15:0]     hash_r, hash_nxt;
  logic [63:0]     gkey_r, gkey_nxt;
  logic [SW-1:0]   h_r, h_nxt;
  logic [SW:0]     p_r, p_nxt;

  // slot memories and their read registers
  logic [1:0]      st_mem [2**AW];
  logic [63:0]     key_mem [2**AW];
  logic [1:0]      st_rd_r;
  logic [63:0]     key_rd_r;
  logic [AW-1:0]   addr;
  logic            st_we, key_we;
  logic [1:0]      st_wd;
  logic [63:0]     key_wd;

  logic [SW:0]     size_w, mask_w, size_n, mask_n, wsize, wmask;
  logic [SW-1:0]   h_step;
  logic            p_last, hit, need_grow, cant_grow, grow_walk;
  logic [15:0]     ghash;

  // table geometry
  always_comb begin
    size_w    = (SW + 1)'(1) << lg_r;
    mask_w    = size_w - (SW + 1)'(1);
    size_n    = size_w << 1;
    mask_n    = size_n - (SW + 1)'(1);
    grow_walk = (state_r == S_GPRD) || (state_r == S_GPEV);
    wsize     = grow_walk ? size_n : size_w;
    wmask     = grow_walk ? mask_n : mask_w;
    h_step    = SW'(({1'b0, h_r} + p_r + (SW + 1)'(1)) & wmask);
    p_last    = (p_r + (SW + 1)'(1)) >= wsize;
    hit       = (st_rd_r == ohs_pkg::ST_LIVE) && (key_rd_r == key_r);
    need_grow = ((GW'(cnt_r) + GW'(1)) << 2) > ((GW'(size_w) << 1) + GW'(size_w));
    cant_grow = (GW'(size_w) << 1) > GW'(MAX_SLOTS);
    ghash     = ohs_pkg::hash16(gkey_r);
  end

  assign clearing      = (state_r == S_CLR);
  assign pop_ready     = (state_r == S_IDLE) && !ov_r;
  assign out_valid     = ov_r;
  assign out_success   = succ_r;
  assign out_full_res  = full_r;
  assign out_live_keys = 10'(cnt_r);

  // sequencer
  always_comb begin
    state_nxt = state_r;
    bank_nxt  = bank_r;
    lg_nxt    = lg_r;
    cnt_nxt   = cnt_r;
    i_nxt     = i_r;
    ov_nxt    = ov_r & ~out_ready;
    succ_nxt  = succ_r;
    full_nxt  = full_r;
    op_nxt    = op_r;
    key_nxt   = key_r;
    hash_nxt  = hash_r;
    gkey_nxt  = gkey_r;
    h_nxt     = h_r;
    p_nxt     = p_r;
    addr      = {bank_r, h_r};
    st_we     = 1'b0;
    key_we    = 1'b0;
    st_wd     = ohs_pkg::ST_EMPTY;
    key_wd    = key_r;
    case (state_r)
      S_CLR: begin
        addr  = i_r;
        st_we = 1'b1;
        if (i_r == {AW{1'b1}}) begin
          i_nxt     = '0;
          state_nxt = S_IDLE;
        end else begin
          i_nxt = i_r + AW'(1);
        end
      end
      S_IDLE: begin
        if (pop_valid && !ov_r) begin
          op_nxt   = pop_data.op;
          key_nxt  = pop_data.key;
          hash_nxt = pop_data.hash;
          h_nxt    = pop_data.hash[SW-1:0] & mask_w[SW-1:0];
          p_nxt    = '0;
          if (pop_data.op == ohs_pkg::OP_INSERT || pop_data.op == ohs_pkg::OP_DELETE ||
              pop_data.op == ohs_pkg::OP_TEST) begin
            state_nxt = S_FIND_RD;
          end else begin
            succ_nxt = 1'b0;
            full_nxt = 1'b0;
            ov_nxt   = 1'b1;
          end
        end
      end
      S_FIND_RD: begin
        state_nxt = S_FIND_EV;
      end
      S_FIND_EV: begin
        if (hit) begin
          full_nxt  = 1'b0;
          ov_nxt    = 1'b1;
          state_nxt = S_IDLE;
          succ_nxt  = (op_r != ohs_pkg::OP_INSERT);
          if (op_r == ohs_pkg::OP_DELETE) begin
            st_we   = 1'b1;
            st_wd   = ohs_pkg::ST_TOMB;
            cnt_nxt = cnt_r - CW'(1);
          end
        end else if (st_rd_r == ohs_pkg::ST_EMPTY || p_last) begin
          if (op_r != ohs_pkg::OP_INSERT) begin
            succ_nxt  = 1'b0;
            full_nxt  = 1'b0;
            ov_nxt    = 1'b1;
            state_nxt = S_IDLE;
          end else if (need_grow && cant_grow) begin
            succ_nxt  = 1'b0;
            full_nxt  = 1'b1;
            ov_nxt    = 1'b1;
            state_nxt = S_IDLE;
          end else if (need_grow) begin
            i_nxt     = '0;
            state_nxt = S_GCLR_NEW;
          end else begin
            h_nxt     = hash_r[SW-1:0] & mask_w[SW-1:0];
            p_nxt     = '0;
            state_nxt = S_INS_RD;
          end
        end else begin
          h_nxt     = h_step;
          p_nxt     = p_r + (SW + 1)'(1);
          state_nxt = S_FIND_RD;
        end
      end
      S_GCLR_NEW: begin
        addr  = {~bank_r, i_r[SW-1:0]};
        st_we = 1'b1;
        if (i_r == mask_n) begin
          i_nxt     = '0;
          state_nxt = S_GRD;
        end else begin
          i_nxt = i_r + AW'(1);
        end
      end
      S_GRD: begin
        addr      = {bank_r, i_r[SW-1:0]};
        state_nxt = S_GEV;
      end
      S_GEV: begin
        if (st_rd_r == ohs_pkg::ST_LIVE) begin
          gkey_nxt  = key_rd_r;
          state_nxt = S_GHASH;
        end else if (i_r == mask_w) begin
          i_nxt     = '0;
          state_nxt = S_GCLR_OLD;
        end else begin
          i_nxt     = i_r + AW'(1);
          state_nxt = S_GRD;
        end
      end
      S_GHASH: begin
        h_nxt     = ghash[SW-1:0] & mask_n[SW-1:0];
        p_nxt     = '0;
        state_nxt = S_GPRD;
      end
      S_GPRD: begin
        addr      = {~bank_r, h_r};
        state_nxt = S_GPEV;
      end
      S_GPEV: begin
        addr = {~bank_r, h_r};
        if (st_rd_r != ohs_pkg::ST_EMPTY && !p_last) begin
          h_nxt     = h_step;
          p_nxt     = p_r + (SW + 1)'(1);
          state_nxt = S_GPRD;
        end else begin
          if (st_rd_r == ohs_pkg::ST_EMPTY) begin
            st_we  = 1'b1;
            st_wd  = ohs_pkg::ST_LIVE;
            key_we = 1'b1;
            key_wd = gkey_r;
          end
          if (i_r == mask_w) begin
            i_nxt     = '0;
            state_nxt = S_GCLR_OLD;
          end else begin
            i_nxt     = i_r + AW'(1);
            state_nxt = S_GRD;
          end
        end
      end
      S_GCLR_OLD: begin
        addr  = {bank_r, i_r[SW-1:0]};
        st_we = 1'b1;
        if (i_r == mask_w) begin
          i_nxt     = '0;
          bank_nxt  = ~bank_r;
          lg_nxt    = lg_r + LW'(1);
          h_nxt     = hash_r[SW-1:0] & mask_n[SW-1:0];
          p_nxt     = '0;
          state_nxt = S_INS_RD;
        end else begin
          i_nxt = i_r + AW'(1);
        end
      end
      S_INS_RD: begin
        state_nxt = S_INS_EV;
      end
      S_INS_EV: begin
        if (st_rd_r == ohs_pkg::ST_EMPTY || st_rd_r == ohs_pkg::ST_TOMB) begin
          st_we     = 1'b1;
          st_wd     = ohs_pkg::ST_LIVE;
          key_we    = 1'b1;
          cnt_nxt   = cnt_r + CW'(1);
          succ_nxt  = 1'b1;
          full_nxt  = 1'b0;
          ov_nxt    = 1'b1;
          state_nxt = S_IDLE;
        end else if (p_last) begin
          succ_nxt  = 1'b0;
          full_nxt  = 1'b1;
          ov_nxt    = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          h_nxt     = h_step;
          p_nxt     = p_r + (SW + 1)'(1);
          state_nxt = S_INS_RD;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      bank_r  <= 1'b0;
      lg_r    <= LW'(START_LOG);
      cnt_r   <= '0;
      i_r     <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      bank_r  <= bank_nxt;
      lg_r    <= lg_nxt;
      cnt_r   <= cnt_nxt;
      i_r     <= i_nxt;
      ov_r    <= ov_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    succ_r <= succ_nxt;
    full_r <= full_nxt;
    op_r   <= op_nxt;
    key_r  <= key_nxt;
    hash_r <= hash_nxt;
    gkey_r <= gkey_nxt;
    h_r    <= h_nxt;
    p_r    <= p_nxt;
  end

  // slot memories, single port with registered read
  always_ff @(posedge clk) begin
    if (st_we) begin
      st_mem[addr] <= st_wd;
    end
    if (key_we) begin
      key_mem[addr] <= key_wd;
    end
    st_rd_r  <= st_mem[addr];
    key_rd_r <= key_mem[addr];
  end

`ifndef SYNTHESIS
  // load never exceeds three quarters of the table
  assert property (@(posedge clk) disable iff (!rst_n)
    (4 * int'(cnt_r)) <= (3 * int'(size_w)))
    else $error("load bound broken");

  // a successful insert adds exactly one live key
  assert property (@(posedge clk) disable iff (!rst_n)
    ($rose(ov_r) && succ_r && op_r == ohs_pkg::OP_INSERT) |->
      (cnt_r == $past(cnt_r) + CW'(1)))
    else $error("insert did not count");

  // a full result only at the largest table size
  assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && full_r) |-> cant_grow)
    else $error("full reported below maximum size");
`endif

endmodule
